### design/ctl_pkg.sv
// Shared types and constants for the C-like token lexer.
package ctl_pkg;

  // Sizing
  localparam int MAX_TOKEN_LEN = 255;
  localparam int POS_WIDTH     = 32;
  localparam int RUN_W         = $clog2(MAX_TOKEN_LEN + 2);
  localparam int BYTE_W        = 8;
  localparam int TYPE_W        = 4;
  localparam int START_W       = 32;
  localparam int LEN_OUT_W     = 8;

  // Result queue
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [RUN_W-1:0]     run_t;

  typedef enum logic [TYPE_W-1:0] {
    TOK_IDENT       = 4'd0,
    TOK_NUMBER      = 4'd1,
    TOK_OPERATOR    = 4'd2,
    TOK_COMPARE     = 4'd3,
    TOK_LOGICAL     = 4'd4,
    TOK_BOOLEAN     = 4'd5,
    TOK_STRING      = 4'd6,
    TOK_OTHER       = 4'd7,
    TOK_OPEN_PAREN  = 4'd8,
    TOK_CLOSE_PAREN = 4'd9,
    TOK_OPEN_BRACE  = 4'd10,
    TOK_CLOSE_BRACE = 4'd11,
    TOK_EOF         = 4'd12
  } tok_type_t;

  // Scanner mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_IDENT   = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_STRING  = 5'b01000,
    MODE_PENDING = 5'b10000
  } mode_t;

  // First half of a possible two-character token
  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_EQ   = 3'd1,
    PEND_BANG = 3'd2,
    PEND_GT   = 3'd3,
    PEND_LT   = 3'd4,
    PEND_AMP  = 3'd5,
    PEND_BAR  = 3'd6
  } pend_t;

  // Keyword tracker: prefix of "true" (1..4) or "false" (5..9)
  typedef logic [3:0] kw_t;
  localparam kw_t KW_NONE  = 4'd0;
  localparam kw_t KW_T     = 4'd1;
  localparam kw_t KW_TR    = 4'd2;
  localparam kw_t KW_TRU   = 4'd3;
  localparam kw_t KW_TRUE  = 4'd4;
  localparam kw_t KW_F     = 4'd5;
  localparam kw_t KW_FA    = 4'd6;
  localparam kw_t KW_FAL   = 4'd7;
  localparam kw_t KW_FALS  = 4'd8;
  localparam kw_t KW_FALSE = 4'd9;

  // One token record
  typedef struct packed {
    tok_type_t               token_type;
    logic [START_W-1:0]      token_start;
    logic [LEN_OUT_W-1:0]    token_length;
    logic                    length_overflow;
    logic                    last_of_run;
  } tok_t;

endpackage

### design/ctl_byte_if.sv
// Input byte channel interface.
interface ctl_byte_if
  import ctl_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

### design/ctl_tok_if.sv
// Token record channel interface.
interface ctl_tok_if
  import ctl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    token_type;
  logic [START_W-1:0]   token_start;
  logic [LEN_OUT_W-1:0] token_length;
  logic                 length_overflow;
  logic                 last_of_run;

  modport source (output valid, output token_type, output token_start, output token_length,
                  output length_overflow, output last_of_run, input ready);
  modport sink   (input valid, input token_type, input token_start, input token_length,
                  input length_overflow, input last_of_run, output ready);
endinterface

### design/c_like_token_lexer_top.sv
// Streaming lexer for a small C-like language: byte in, token records out.
//
//   channel  dir  payload                                     transfer
//   in_ch    in   text_byte                                   valid && ready
//   out_ch   out  token_type, token_start, token_length,      valid && ready
//                 length_overflow, last_of_run
//
// One byte is taken per cycle; its 0, 1 or 2 records are written into a 4-entry
// result queue at that edge and are offered from the next cycle, one per cycle.
// in_ch.ready is high while the queue holds at most two records, so a stream that
// makes at most one record per byte runs at one byte per cycle; two-record bytes
// are paced by the single output port. Reset (rst, synchronous) returns the
// scanner to idle at position zero and empties the queue. A stalled out_ch lets
// records pile up, and in_ch.ready drops once three or more are waiting.
module c_like_token_lexer_top
  import ctl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ctl_byte_if.sink      in_ch,
  ctl_tok_if.source     out_ch
);

  // Effect of lexing a byte as the first byte of a token
  typedef struct packed {
    mode_t     mode;
    pend_t     pend;
    kw_t       kw;
    logic      begin_load;
    pos_t      begin_val;
    run_t      run;
    logic      emit;
    tok_type_t etype;
    logic      ended;
  } start_t;

  // Scanner state
  mode_t mode, mode_next;
  pend_t pend, pend_next;
  kw_t   kw, kw_next;
  pos_t  token_begin, token_begin_next;
  run_t  run_length, run_length_next;
  pos_t  position, position_next;

  // Result queue
  tok_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic [QCNT_W-1:0] count;

  logic  accept, pop;
  byte_t b;
  tok_t  e0, e1;
  logic  e0_valid, e1_valid;
  logic  use_start;
  start_t st;

  function automatic logic is_digit(byte_t c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(byte_t c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(byte_t c);
    return c inside {" ", [8'd9:8'd13]};
  endfunction

  // Build a record from a byte count, saturating the length
  function automatic tok_t make_tok(tok_type_t t, pos_t s, run_t cnt);
    tok_t r;
    logic ovf;
    run_t lim;
    ovf = cnt > RUN_W'(MAX_TOKEN_LEN);
    lim = ovf ? RUN_W'(MAX_TOKEN_LEN) : cnt;
    r.token_type      = t;
    r.token_start     = START_W'(s);
    r.token_length    = LEN_OUT_W'(lim);
    r.length_overflow = ovf;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  // Step the true/false prefix tracker
  function automatic kw_t kw_step(kw_t k, byte_t c);
    byte_t want;
    logic  live;
    live = 1'b1;
    want = "e";
    case (k)
      KW_T:    want = "r";
      KW_TR:   want = "u";
      KW_TRU:  want = "e";
      KW_F:    want = "a";
      KW_FA:   want = "l";
      KW_FAL:  want = "s";
      KW_FALS: want = "e";
      default: live = 1'b0;
    endcase
    return (live && c == want) ? k + kw_t'(1) : KW_NONE;
  endfunction

  function automatic start_t lex_start(byte_t c, pos_t p);
    start_t s;
    s.mode       = MODE_IDLE;
    s.pend       = PEND_NONE;
    s.kw         = KW_NONE;
    s.begin_load = 1'b0;
    s.begin_val  = p;
    s.run        = '0;
    s.emit       = 1'b0;
    s.etype      = TOK_OTHER;
    s.ended      = 1'b0;
    if (c == 8'd0) begin
      s.emit  = 1'b1;
      s.etype = TOK_EOF;
      s.ended = 1'b1;
    end else if (!is_space(c)) begin
      case (c)
        "(": begin s.emit = 1'b1; s.etype = TOK_OPEN_PAREN; end
        ")": begin s.emit = 1'b1; s.etype = TOK_CLOSE_PAREN; end
        "{": begin s.emit = 1'b1; s.etype = TOK_OPEN_BRACE; end
        "}": begin s.emit = 1'b1; s.etype = TOK_CLOSE_BRACE; end
        "=", "!", ">", "<", "&", "|": begin
          s.mode       = MODE_PENDING;
          s.begin_load = 1'b1;
          case (c)
            "=":     s.pend = PEND_EQ;
            "!":     s.pend = PEND_BANG;
            ">":     s.pend = PEND_GT;
            "<":     s.pend = PEND_LT;
            "&":     s.pend = PEND_AMP;
            default: s.pend = PEND_BAR;
          endcase
        end
        "\"": begin
          s.mode       = MODE_STRING;
          s.begin_load = 1'b1;
          s.begin_val  = p + pos_t'(1);
        end
        "+", "-", "*", "/": begin s.emit = 1'b1; s.etype = TOK_OPERATOR; end
        default: begin
          if (is_digit(c)) begin
            s.mode       = MODE_NUMBER;
            s.begin_load = 1'b1;
            s.run        = run_t'(1);
          end else if (is_alpha(c)) begin
            s.mode       = MODE_IDENT;
            s.begin_load = 1'b1;
            s.run        = run_t'(1);
            s.kw         = (c == "t") ? KW_T : (c == "f") ? KW_F : KW_NONE;
          end else begin
            s.emit = 1'b1;
          end
        end
      endcase
    end
    return s;
  endfunction

  assign b      = in_ch.text_byte;
  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign st     = lex_start(b, position);

  // Per-byte scanner step
  always_comb begin
    mode_next        = mode;
    pend_next        = pend;
    kw_next          = kw;
    token_begin_next = token_begin;
    run_length_next  = run_length;
    position_next    = position + pos_t'(1);
    e0_valid         = 1'b0;
    e0               = make_tok(TOK_IDENT, token_begin, run_length);
    use_start        = 1'b0;
    case (mode)
      MODE_IDENT: begin
        if (is_digit(b) || is_alpha(b)) begin
          kw_next = kw_step(kw, b);
          if (run_length <= RUN_W'(MAX_TOKEN_LEN)) run_length_next = run_length + run_t'(1);
        end else begin
          e0_valid  = 1'b1;
          e0        = make_tok((kw == KW_TRUE || kw == KW_FALSE) ? TOK_BOOLEAN : TOK_IDENT,
                               token_begin, run_length);
          use_start = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(b)) begin
          if (run_length <= RUN_W'(MAX_TOKEN_LEN)) run_length_next = run_length + run_t'(1);
        end else begin
          e0_valid  = 1'b1;
          e0        = make_tok(TOK_NUMBER, token_begin, run_length);
          use_start = 1'b1;
        end
      end
      MODE_STRING: begin
        if (b == "\"") begin
          e0_valid        = 1'b1;
          e0              = make_tok(TOK_STRING, token_begin, run_length);
          mode_next       = MODE_IDLE;
          run_length_next = '0;
        end else if (b == 8'd0) begin
          e0_valid  = 1'b1;
          e0        = make_tok(TOK_STRING, token_begin, run_length);
          use_start = 1'b1;
        end else if (run_length <= RUN_W'(MAX_TOKEN_LEN)) begin
          run_length_next = run_length + run_t'(1);
        end
      end
      MODE_PENDING: begin
        e0_valid = 1'b1;
        if (b == "=" && (pend == PEND_EQ || pend == PEND_BANG ||
                         pend == PEND_GT || pend == PEND_LT)) begin
          e0        = make_tok(TOK_COMPARE, token_begin, run_t'(2));
          mode_next = MODE_IDLE;
          pend_next = PEND_NONE;
        end else if ((b == "&" && pend == PEND_AMP) || (b == "|" && pend == PEND_BAR)) begin
          e0        = make_tok(TOK_LOGICAL, token_begin, run_t'(2));
          mode_next = MODE_IDLE;
          pend_next = PEND_NONE;
        end else begin
          e0        = make_tok((pend == PEND_GT || pend == PEND_LT) ? TOK_COMPARE : TOK_OTHER,
                               token_begin, run_t'(1));
          use_start = 1'b1;
        end
      end
      default: use_start = 1'b1;
    endcase

    e1_valid = use_start && st.emit;
    e1       = make_tok(st.etype, position, st.etype == TOK_EOF ? run_t'(0) : run_t'(1));
    if (use_start) begin
      mode_next       = st.mode;
      pend_next       = st.pend;
      kw_next         = st.kw;
      run_length_next = st.run;
      if (st.begin_load) token_begin_next = st.begin_val;
    end
    // End of text: back to the reset state
    if (use_start && st.ended) begin
      mode_next        = MODE_IDLE;
      pend_next        = PEND_NONE;
      kw_next          = KW_NONE;
      token_begin_next = '0;
      run_length_next  = '0;
      position_next    = '0;
    end
    // Mark the final record of this byte
    if (e1_valid) e1.last_of_run = 1'b1;
    else          e0.last_of_run = 1'b1;
  end

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      pend        <= PEND_NONE;
      kw          <= KW_NONE;
      token_begin <= '0;
      run_length  <= '0;
      position    <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      pend        <= pend_next;
      kw          <= kw_next;
      token_begin <= token_begin_next;
      run_length  <= run_length_next;
      position    <= position_next;
    end
  end

  // Queue write: records of one byte go in order from the tail
  always_ff @(posedge clk) begin
    if (accept) begin
      if (e0_valid) begin
        q[tail] <= e0;
        if (e1_valid) q[tail + QPTR_W'(1)] <= e1;
      end else if (e1_valid) begin
        q[tail] <= e1;
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    logic [QCNT_W-1:0] n_push;
    n_push = accept ? (QCNT_W'(e0_valid) + QCNT_W'(e1_valid)) : '0;
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QPTR_W'(n_push);
      if (pop) head <= head + QPTR_W'(1);
      count <= count + n_push - QCNT_W'(pop);
    end
  end

  assign in_ch.ready            = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign out_ch.valid           = count != '0;
  assign out_ch.token_type      = q[head].token_type;
  assign out_ch.token_start     = q[head].token_start;
  assign out_ch.token_length    = q[head].token_length;
  assign out_ch.length_overflow = q[head].length_overflow;
  assign out_ch.last_of_run     = q[head].last_of_run;

endmodule

### verif/ctl_token_checker.sv
// Token stream checker: follows accepted text bytes, predicts token records, compares them.
`timescale 1ns / 1ps

module ctl_token_checker
  import ctl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ctl_byte_if  in_ch,
  ctl_tok_if   out_ch,
  output int   mismatches,
  output int   queued_tokens,
  output int   tokens_checked,
  output int   texts_ended,
  output int   overflowed
);

  // Predicted scanner state
  mode_t  scan_mode;
  pend_t  pend;
  kw_t    kw;
  pos_t   tok_begin;
  run_t   run_len;
  pos_t   byte_pos;

  tok_t   step_tokens[$];     // records made by the byte in flight
  tok_t   expected_tokens[$]; // records still to arrive, oldest first

  int     error_count;
  int     checked_count;
  int     eof_count;
  int     overflow_count;

  function automatic bit is_digit(byte_t b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(byte_t b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic clear_scanner();
    scan_mode = MODE_IDLE;
    pend      = PEND_NONE;
    kw        = KW_NONE;
    tok_begin = '0;
    run_len   = '0;
    byte_pos  = '0;
  endtask

  // Queue one record for this byte; length saturates, overflow flags it
  task automatic push_token(input tok_type_t kind, input pos_t start, input run_t count);
    tok_t t;
    t.token_type      = kind;
    t.token_start     = start;
    t.token_length    = (count > MAX_TOKEN_LEN) ? LEN_OUT_W'(MAX_TOKEN_LEN)
                                                : count[LEN_OUT_W-1:0];
    t.length_overflow = count > MAX_TOKEN_LEN;
    t.last_of_run     = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic bump_run();
    if (run_len <= MAX_TOKEN_LEN) run_len++;
  endtask

  // Lex b as the first byte of a fresh token; ended goes high on end of text
  task automatic begin_token(input byte_t b, input pos_t p, output bit ended);
    scan_mode = MODE_IDLE;
    pend      = PEND_NONE;
    kw        = KW_NONE;
    run_len   = '0;
    ended     = 1'b0;
    if (b == 8'h00) begin
      push_token(TOK_EOF, p, run_t'(0));
      ended = 1'b1;
    end else if (!(b == " " || (b >= 8'd9 && b <= 8'd13))) begin
      case (b)
        "(": push_token(TOK_OPEN_PAREN, p, run_t'(1));
        ")": push_token(TOK_CLOSE_PAREN, p, run_t'(1));
        "{": push_token(TOK_OPEN_BRACE, p, run_t'(1));
        "}": push_token(TOK_CLOSE_BRACE, p, run_t'(1));
        "=", "!", ">", "<", "&", "|": begin
          scan_mode = MODE_PENDING;
          tok_begin = p;
          case (b)
            "=":     pend = PEND_EQ;
            "!":     pend = PEND_BANG;
            ">":     pend = PEND_GT;
            "<":     pend = PEND_LT;
            "&":     pend = PEND_AMP;
            default: pend = PEND_BAR;
          endcase
        end
        "\"": begin
          scan_mode = MODE_STRING;
          tok_begin = p + 1'b1;
        end
        "+", "-", "*", "/": push_token(TOK_OPERATOR, p, run_t'(1));
        default: begin
          if (is_digit(b)) begin
            scan_mode = MODE_NUMBER;
            tok_begin = p;
            run_len   = run_t'(1);
          end else if (is_alpha(b)) begin
            scan_mode = MODE_IDENT;
            tok_begin = p;
            run_len   = run_t'(1);
            kw        = (b == "t") ? KW_T : (b == "f") ? KW_F : KW_NONE;
          end else begin
            push_token(TOK_OTHER, p, run_t'(1));
          end
        end
      endcase
    end
  endtask

  // Advance the predictor by one accepted byte
  task automatic lex_byte(input byte_t b);
    pos_t here;
    bit   ended;
    here  = byte_pos;
    ended = 1'b0;
    step_tokens.delete();
    case (scan_mode)
      MODE_IDENT: begin
        if (is_digit(b) || is_alpha(b)) begin
          // track "true" / "false" spelling
          case (kw)
            KW_T:    kw = (b == "r") ? KW_TR   : KW_NONE;
            KW_TR:   kw = (b == "u") ? KW_TRU  : KW_NONE;
            KW_TRU:  kw = (b == "e") ? KW_TRUE : KW_NONE;
            KW_F:    kw = (b == "a") ? KW_FA   : KW_NONE;
            KW_FA:   kw = (b == "l") ? KW_FAL  : KW_NONE;
            KW_FAL:  kw = (b == "s") ? KW_FALS : KW_NONE;
            KW_FALS: kw = (b == "e") ? KW_FALSE : KW_NONE;
            default: kw = KW_NONE;
          endcase
          bump_run();
        end else begin
          push_token((kw == KW_TRUE || kw == KW_FALSE) ? TOK_BOOLEAN : TOK_IDENT,
                     tok_begin, run_len);
          begin_token(b, here, ended);
        end
      end
      MODE_NUMBER: begin
        if (is_digit(b)) begin
          bump_run();
        end else begin
          push_token(TOK_NUMBER, tok_begin, run_len);
          begin_token(b, here, ended);
        end
      end
      MODE_STRING: begin
        if (b == "\"") begin
          push_token(TOK_STRING, tok_begin, run_len);
          scan_mode = MODE_IDLE;
          run_len   = '0;
        end else if (b == 8'h00) begin
          // unterminated string closes at end of text
          push_token(TOK_STRING, tok_begin, run_len);
          begin_token(b, here, ended);
        end else begin
          bump_run();
        end
      end
      MODE_PENDING: begin
        if (b == "=" && (pend == PEND_EQ || pend == PEND_BANG ||
                         pend == PEND_GT || pend == PEND_LT)) begin
          push_token(TOK_COMPARE, tok_begin, run_t'(2));
          scan_mode = MODE_IDLE;
          pend      = PEND_NONE;
        end else if ((b == "&" && pend == PEND_AMP) || (b == "|" && pend == PEND_BAR)) begin
          push_token(TOK_LOGICAL, tok_begin, run_t'(2));
          scan_mode = MODE_IDLE;
          pend      = PEND_NONE;
        end else begin
          // lone first character, then lex this byte afresh
          push_token((pend == PEND_GT || pend == PEND_LT) ? TOK_COMPARE : TOK_OTHER,
                     tok_begin, run_t'(1));
          begin_token(b, here, ended);
        end
      end
      default: begin_token(b, here, ended);
    endcase

    if (ended) begin
      clear_scanner();
      eof_count++;
    end else begin
      byte_pos = here + 1'b1;
    end

    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  // Compare one transferred record against the oldest prediction
  task automatic check_token();
    tok_t want;
    if (expected_tokens.size() == 0) begin
      report_error($sformatf("record type %0d start %0d with nothing expected",
                             out_ch.token_type, out_ch.token_start));
      return;
    end
    want = expected_tokens.pop_front();
    checked_count++;
    if (want.length_overflow) overflow_count++;
    if (out_ch.token_type !== want.token_type)
      report_error($sformatf("token_type %0d, expected %0d (start %0d)",
                             out_ch.token_type, want.token_type, want.token_start));
    if (out_ch.token_start !== want.token_start)
      report_error($sformatf("token_start %0d, expected %0d",
                             out_ch.token_start, want.token_start));
    if (out_ch.token_length !== want.token_length)
      report_error($sformatf("token_length %0d, expected %0d (start %0d)",
                             out_ch.token_length, want.token_length, want.token_start));
    if (out_ch.length_overflow !== want.length_overflow)
      report_error($sformatf("length_overflow %0b, expected %0b (start %0d)",
                             out_ch.length_overflow, want.length_overflow, want.token_start));
    if (out_ch.last_of_run !== want.last_of_run)
      report_error($sformatf("last_of_run %0b, expected %0b (start %0d)",
                             out_ch.last_of_run, want.last_of_run, want.token_start));
  endtask

  initial begin
    clear_scanner();
    error_count    = 0;
    checked_count  = 0;
    eof_count      = 0;
    overflow_count = 0;
  end

  // Predictions go in before the compare so a same-cycle record still matches
  always @(posedge clk) begin
    if (rst) begin
      clear_scanner();
      expected_tokens.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) lex_byte(in_ch.text_byte);
      if (out_ch.valid && out_ch.ready) check_token();
    end
    mismatches     <= error_count;
    queued_tokens  <= expected_tokens.size();
    tokens_checked <= checked_count;
    texts_ended    <= eof_count;
    overflowed     <= overflow_count;
  end

endmodule

### verif/c_like_token_lexer_top_tb.sv
// Testbench top for the token lexer: clock, reset, text stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module c_like_token_lexer_top_tb;
  import ctl_pkg::*;

  localparam int    RANDOM_BYTES = 260;
  localparam int    DRAIN_LIMIT  = 20000;
  localparam string LONE_CHARS   = "=!><&|";
  localparam string SINGLE_CHARS = "(){}+-*/";

  logic clk;
  logic rst;
  bit   no_idle;
  int   bytes_sent;
  int   random_start;
  int   drain_cycles;

  int   mismatches;
  int   queued_tokens;
  int   tokens_checked;
  int   texts_ended;
  int   overflowed;

  ctl_byte_if in_ch();
  ctl_tok_if  out_ch();

  c_like_token_lexer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ctl_token_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .queued_tokens  (queued_tokens),
    .tokens_checked (tokens_checked),
    .texts_ended    (texts_ended),
    .overflowed     (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver backpressure, off during the steady stretch
  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 30);
  end

  // One byte transfer, with an occasional idle gap before it
  task automatic send_byte(input byte_t b);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_word(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic byte_t random_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? byte_t'("a" + r) : byte_t'("A" + r - 26);
  endfunction

  function automatic byte_t random_alnum();
    return ($urandom_range(2) == 0) ? byte_t'("0" + $urandom_range(9)) : random_letter();
  endfunction

  // Any string body byte: nonzero and not a quote
  function automatic byte_t random_string_byte();
    byte_t b;
    do b = byte_t'($urandom_range(1, 255)); while (b == "\"");
    return b;
  endfunction

  // Token longer than a short one; kind picks identifier, number or string
  task automatic send_long_token(input tok_type_t kind, input int len);
    case (kind)
      TOK_IDENT: begin
        send_byte(random_letter());
        repeat (len - 1) send_byte(random_alnum());
      end
      TOK_NUMBER: repeat (len) send_byte(byte_t'("0" + $urandom_range(9)));
      default: begin
        send_byte("\"");
        repeat (len) send_byte(random_string_byte());
      end
    endcase
  endtask

  // One random token, well formed most of the time, then maybe whitespace
  task automatic send_random_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 22) begin
      case ($urandom_range(7))
        0: send_word("true");
        1: send_word("false");
        2: send_word("tru");
        3: send_word("falsey");
        4: send_word("true9");
        default: begin
          send_byte(random_letter());
          repeat ($urandom_range(0, 7)) send_byte(random_alnum());
        end
      endcase
    end else if (pick < 38) begin
      repeat ($urandom_range(1, 6)) send_byte(byte_t'("0" + $urandom_range(9)));
    end else if (pick < 50) begin
      send_byte("\"");
      repeat ($urandom_range(0, 6)) send_byte(random_string_byte());
      send_byte("\"");
    end else if (pick < 65) begin
      case ($urandom_range(5))
        0: send_word("==");
        1: send_word("!=");
        2: send_word(">=");
        3: send_word("<=");
        4: send_word("&&");
        default: send_word("||");
      endcase
    end else if (pick < 73) begin
      send_byte(LONE_CHARS[$urandom_range(5)]);
    end else if (pick < 85) begin
      send_byte(SINGLE_CHARS[$urandom_range(7)]);
    end else begin
      send_byte(byte_t'($urandom_range(1, 255)));
    end
    if ($urandom_range(1) == 0) begin
      pick = $urandom_range(8, 13);
      send_byte((pick == 8) ? byte_t'(" ") : byte_t'(pick));
    end
  endtask

  initial begin
    rst             = 1'b1;
    no_idle         = 1'b0;
    bytes_sent      = 0;
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed text: brackets, ident with digits, two-char tokens, number then
    // letters, empty string, boolean, a high byte, end of text
    send_word("(t1>=9a){\"\"}<=&&||!=true");
    send_byte(8'h80);
    send_byte(8'h00);

    // Saturation: identifier at the exact limit, then an unterminated string one past it
    send_long_token(TOK_IDENT, MAX_TOKEN_LEN);
    send_byte(" ");
    send_long_token(TOK_STRING, MAX_TOKEN_LEN + 1);
    send_byte(8'h00);

    // Random texts, each closed by a zero byte
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      no_idle = (bytes_sent - random_start) inside {[60:200]};
      repeat ($urandom_range(3, 15)) send_random_token();
      case ($urandom_range(9))
        0, 1: begin
          send_byte("\"");
          repeat ($urandom_range(0, 4)) send_byte(random_string_byte());
        end
        2: send_byte(LONE_CHARS[$urandom_range(5)]);
        default: ;
      endcase
      send_byte(8'h00);
    end

    // Drain outstanding records, then a short settle
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk);
    drain_cycles = 0;
    while (queued_tokens != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (16) @(posedge clk);

    if (queued_tokens != 0) $display("%0d predicted token records never arrived", queued_tokens);
    $display("Run covered %0d text bytes over %0d ended texts.", bytes_sent, texts_ended);
    $display("%0d token records compared, %0d of them past the length limit.",
             tokens_checked, overflowed);
    if (mismatches == 0 && queued_tokens == 0) begin
      $display("c_like_token_lexer_top test passed");
    end else begin
      $display("c_like_token_lexer_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("c_like_token_lexer_top test failed");
    $finish;
  end

endmodule
